FILE: rtl/jrc_pkg.sv
// Shared types, codes and reset values for the jog ramp controller.
`timescale 1ns / 1ps

package jrc_pkg;

   // Default width of the controlled value.
   localparam int VALUE_WIDTH_DEF = 16;

   // Configuration port geometry.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register reset values.
   localparam logic [15:0]        DAMP_RESET     = 16'd62259;
   localparam logic [14:0]        STEP_RESET     = 15'd66;
   localparam logic signed [15:0] UPPER_RESET    = 16'sd16384;
   localparam logic signed [15:0] LOWER_RESET    = -16'sd16384;
   localparam logic               LINEAR_RESET   = 1'b0;
   localparam logic               MULTIPLY_RESET = 1'b1;

   // Commands carried in tuser of the request channel.
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_LESS = 2'd1,
      CMD_MORE = 2'd2,
      CMD_STOP = 2'd3
   } jrc_cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DAMP     = 3'd0,
      REG_STEP     = 3'd1,
      REG_UPPER    = 3'd2,
      REG_LOWER    = 3'd3,
      REG_LINEAR   = 3'd4,
      REG_MULTIPLY = 3'd5
   } jrc_reg_type;

   // Configuration register set.
   typedef struct packed {
      logic [15:0]        damp_factor;
      logic [14:0]        step_size;
      logic signed [15:0] upper_bound;
      logic signed [15:0] lower_bound;
      logic               linear_mode;
      logic               multiply_mode;
   } jrc_cfg_type;

   // Control state other than the value itself.
   typedef struct packed {
      logic signed [15:0] step;
      logic               more_held;
      logic               less_held;
      logic               stop_held;
      logic               active;
   } jrc_ctrl_type;

endpackage

FILE: rtl/jrc_update.sv
// Next-state logic of the jog ramp controller for one command.
`timescale 1ns / 1ps

module jrc_update #(
   parameter int VALUE_WIDTH = jrc_pkg::VALUE_WIDTH_DEF
) (
   input  jrc_pkg::jrc_cmd_type         cmd_i,
   input  logic                         level_i,
   input  jrc_pkg::jrc_cfg_type         cfg_i,
   input  jrc_pkg::jrc_ctrl_type        ctrl_i,
   input  logic signed [VALUE_WIDTH-1:0] value_i,
   output jrc_pkg::jrc_ctrl_type        ctrl_o,
   output logic signed [VALUE_WIDTH-1:0] value_o
);
   import jrc_pkg::*;

   // Working width is the wider of the value and 16 bits, plus two spare bits.
   localparam int WW = ((VALUE_WIDTH > 16) ? VALUE_WIDTH : 16) + 2;
   localparam logic signed [WW-1:0] VMAX =
      {{(WW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [WW-1:0] VMIN =
      {{(WW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   logic signed [WW-1:0]          v_ext;
   logic signed [WW-1:0]          sum;
   logic signed [WW-1:0]          clamped;
   logic signed [WW-1:0]          sat;
   logic signed [VALUE_WIDTH-1:0] v_a;
   logic signed [WW-1:0]          va_ext;
   logic signed [WW-1:0]          s_w;
   logic signed [WW-1:0]          d_dn;
   logic signed [WW-1:0]          d_up;
   logic [VALUE_WIDTH-1:0]        mag;
   logic [VALUE_WIDTH+15:0]       prod;
   logic [VALUE_WIDTH-1:0]        p;
   logic signed [VALUE_WIDTH-1:0] r;
   logic signed [VALUE_WIDTH-1:0] mdamp;
   logic signed [VALUE_WIDTH-1:0] lin;
   logic signed [VALUE_WIDTH-1:0] tick_value;
   logic signed [15:0]            s_pos;
   logic signed [15:0]            s_neg;

   // Step while active: add, clamp to the bounds (upper test first), saturate.
   always_comb begin
      v_ext = WW'(value_i);
      sum   = v_ext + WW'(ctrl_i.step);
      if (sum > WW'(cfg_i.upper_bound)) begin
         clamped = WW'(cfg_i.upper_bound);
      end else if (sum < WW'(cfg_i.lower_bound)) begin
         clamped = WW'(cfg_i.lower_bound);
      end else begin
         clamped = sum;
      end
      if (clamped > VMAX) begin
         sat = VMAX;
      end else if (clamped < VMIN) begin
         sat = VMIN;
      end else begin
         sat = clamped;
      end
      v_a = ctrl_i.active ? sat[VALUE_WIDTH-1:0] : value_i;
   end

   // Multiplicative damping on the magnitude, truncating toward zero.
   always_comb begin
      mag   = v_a[VALUE_WIDTH-1] ? (~v_a[VALUE_WIDTH-1:0] + 1'b1) : v_a[VALUE_WIDTH-1:0];
      prod  = (VALUE_WIDTH+16)'(mag) * (VALUE_WIDTH+16)'(cfg_i.damp_factor);
      p     = prod[VALUE_WIDTH+15:16];
      r     = v_a[VALUE_WIDTH-1] ? signed'(~p + 1'b1) : signed'(p);
      mdamp = (r == v_a) ? '0 : r;
   end

   // Step decay toward zero, damping within a step; then pick the tick value.
   always_comb begin
      va_ext = WW'(v_a);
      s_w    = WW'({1'b0, cfg_i.step_size});
      d_dn   = va_ext - s_w;
      d_up   = va_ext + s_w;
      if (va_ext > s_w) begin
         lin = (d_dn < s_w) ? '0 : d_dn[VALUE_WIDTH-1:0];
      end else if (va_ext < -s_w) begin
         lin = (d_up > -s_w) ? '0 : d_up[VALUE_WIDTH-1:0];
      end else begin
         lin = mdamp;
      end
      if (cfg_i.multiply_mode) begin
         tick_value = mdamp;
      end else if (cfg_i.linear_mode && !ctrl_i.active) begin
         tick_value = lin;
      end else begin
         tick_value = v_a;
      end
   end

   // Command decode: a tick ages the value, buttons update the step.
   always_comb begin
      s_pos   = signed'({1'b0, cfg_i.step_size});
      s_neg   = -s_pos;
      ctrl_o  = ctrl_i;
      value_o = value_i;
      unique case (cmd_i)
         CMD_TICK: begin
            value_o = tick_value;
         end
         CMD_LESS: begin
            ctrl_o.less_held = level_i;
            if (level_i) begin
               ctrl_o.active = 1'b1;
               ctrl_o.step   = s_neg;
            end else if (ctrl_i.more_held) begin
               ctrl_o.step = s_pos;
            end else begin
               ctrl_o.active = 1'b0;
               ctrl_o.step   = '0;
            end
         end
         CMD_MORE: begin
            ctrl_o.more_held = level_i;
            if (level_i) begin
               ctrl_o.active = 1'b1;
               ctrl_o.step   = s_pos;
            end else if (ctrl_i.less_held) begin
               ctrl_o.step = s_neg;
            end else begin
               ctrl_o.active = 1'b0;
               ctrl_o.step   = '0;
            end
         end
         CMD_STOP: begin
            ctrl_o.stop_held = level_i;
            if (level_i) begin
               if (value_i > 0) begin
                  ctrl_o.step = s_neg;
               end else if (value_i < 0) begin
                  ctrl_o.step = s_pos;
               end
            end else if (ctrl_i.less_held && !ctrl_i.more_held) begin
               ctrl_o.step = s_neg;
            end else if (!ctrl_i.less_held && ctrl_i.more_held) begin
               ctrl_o.step = s_pos;
            end
         end
         default: begin
            value_o = value_i;
         end
      endcase
   end

endmodule

FILE: rtl/jog_ramp_controller_with_damping_unit.sv
// Top level of the jog ramp controller with damping.
`timescale 1ns / 1ps

// Usage
// The request channel carries one command per beat: tuser holds the command
// (tick, less, more or stop) and tdata bit 0 the new button level. For every
// request beat exactly one response beat follows, in order, carrying the
// axis value (signed Q1.14, tdata[15:0]) and the active flag (tdata[16]).
// The csr channel writes one configuration register per beat and is always
// ready; registers are meant to be written while no command is in flight.
// A request beat is registered in the request register, then passes through
// the update logic into the response register. Throughput is one command per
// cycle while the response side does not stall; the state feedback from one
// command to the next closes through the step adder, clamp, one value-by-damp
// multiplier and the linear decay adders.
// Reset clears the value, step, button flags and both pipeline stages and
// loads the register defaults. When the response side stalls, the response
// register holds its beat and one further command waits in the request
// register; req_tready then falls until the response beat is taken.
module jog_ramp_controller_with_damping_unit #(
   parameter int VALUE_WIDTH = jrc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [0] button_level
   input  logic [1:0]                           req_tuser,  // [1:0] cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,  // [15:0] axis_value, [16] is_active
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jrc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [jrc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import jrc_pkg::*;

   jrc_cfg_type                   cfg_ff, cfg_in;
   jrc_ctrl_type                  ctrl_ff, ctrl_next;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_next;
   logic                          s1_valid_ff, s1_valid_in;
   jrc_cmd_type                   s1_cmd_ff;
   logic                          s1_level_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [23:0]                   rsp_data_ff;
   logic                          out_free;
   logic                          s1_fire;
   logic                          req_beat;
   logic signed [15:0]            axis_value;

   // Handshake: the request stage moves on whenever the response register frees.
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_tready   = !s1_valid_ff || out_free;
   assign req_beat     = req_tvalid && req_tready;
   assign s1_valid_in  = req_beat || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DAMP:     cfg_in.damp_factor   = csr_data;
            REG_STEP:     cfg_in.step_size     = csr_data[14:0];
            REG_UPPER:    cfg_in.upper_bound   = signed'(csr_data);
            REG_LOWER:    cfg_in.lower_bound   = signed'(csr_data);
            REG_LINEAR:   cfg_in.linear_mode   = csr_data[0];
            REG_MULTIPLY: cfg_in.multiply_mode = csr_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Update logic between the request register and the response register.
   jrc_update #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_jrc_update (
      .cmd_i   (s1_cmd_ff),
      .level_i (s1_level_ff),
      .cfg_i   (cfg_ff),
      .ctrl_i  (ctrl_ff),
      .value_i (value_ff),
      .ctrl_o  (ctrl_next),
      .value_o (value_next)
   );

   assign axis_value = 16'(value_next);

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.damp_factor   <= DAMP_RESET;
         cfg_ff.step_size     <= STEP_RESET;
         cfg_ff.upper_bound   <= UPPER_RESET;
         cfg_ff.lower_bound   <= LOWER_RESET;
         cfg_ff.linear_mode   <= LINEAR_RESET;
         cfg_ff.multiply_mode <= MULTIPLY_RESET;
         ctrl_ff              <= '0;
         value_ff             <= '0;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            ctrl_ff  <= ctrl_next;
            value_ff <= value_next;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_cmd_ff   <= jrc_cmd_type'(req_tuser);
         s1_level_ff <= req_tdata[0];
      end
      if (s1_fire) begin
         rsp_data_ff <= {7'd0, ctrl_next.active, axis_value};
      end
   end

endmodule

FILE: rtl/jrc_checker.sv
// Port-level checks for the jog ramp controller, bound to the top level.
`timescale 1ns / 1ps

module jrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled response beat keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Nothing is presented in the first cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // With the response register empty the block always takes a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty response register");

   // A request beat is followed by response valid past both registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("no response two cycles after a request beat");

endmodule

bind jog_ramp_controller_with_damping_unit jrc_checker u_jrc_checker (.*);

FILE: sim/jrc_axis_checker.sv
// Response predictor and scoreboard for the jog ramp controller.
`timescale 1ns / 1ps

module jrc_axis_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [0] button_level
   input  logic [1:0]                          req_tuser,  // [1:0] cmd
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [23:0]                         rsp_tdata,  // [15:0] axis_value, [16] is_active
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [jrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [jrc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  compared_count
);

   localparam longint AXIS_MAX = (longint'(1) <<< (jrc_pkg::VALUE_WIDTH_DEF - 1)) - 1;
   localparam longint AXIS_MIN = -AXIS_MAX - 1;

   // One predicted response beat.
   typedef struct packed {
      logic signed [15:0] axis;
      logic               active;
   } axis_report_type;

   axis_report_type axis_reports_q[$];

   // Local copy of the configuration registers.
   logic [15:0]        damp_q16;
   logic [14:0]        jog_step_size;
   logic signed [15:0] upper_lim;
   logic signed [15:0] lower_lim;
   logic               lin_decay;
   logic               mul_decay;

   // Local copy of the controller state.
   logic signed [15:0] axis_val;
   logic signed [15:0] axis_step;
   logic               more_btn;
   logic               less_btn;
   logic               stop_btn;
   logic               jog_active;

   int fails;
   int compared;

   // Scale by the damp factor, truncating toward zero; an unchanged value collapses to zero.
   function automatic longint damp_scale(longint v);
      longint mag;
      longint p;
      mag = (v < 0) ? -v : v;
      p = (mag * longint'(damp_q16)) >>> 16;
      if (v < 0) p = -p;
      return (p == v) ? longint'(0) : p;
   endfunction

   // One tick: step and clamp while active, then multiplicative or linear decay.
   function automatic void age_axis();
      longint v;
      longint s;
      v = longint'(axis_val);
      s = longint'(jog_step_size);
      if (jog_active) begin
         v = v + longint'(axis_step);
         // The upper test wins when the bounds are inverted.
         if (v > longint'(upper_lim)) v = longint'(upper_lim);
         else if (v < longint'(lower_lim)) v = longint'(lower_lim);
         if (v > AXIS_MAX) v = AXIS_MAX;
         else if (v < AXIS_MIN) v = AXIS_MIN;
      end
      if (mul_decay) begin
         v = damp_scale(v);
      end else if (lin_decay && !jog_active) begin
         if (v > s) begin
            v = v - s;
            if (v < s) v = 0;
         end else if (v < -s) begin
            v = v + s;
            if (v > -s) v = 0;
         end else begin
            v = damp_scale(v);
         end
      end
      axis_val = v[15:0];
   endfunction

   // A more or less button edge; the step is latched from the current step size.
   function automatic void press_direction(logic level, logic toward_more);
      logic signed [15:0] size;
      logic signed [15:0] own;
      logic               other_held;
      size = $signed({1'b0, jog_step_size});
      own = toward_more ? size : -size;
      if (toward_more) begin
         more_btn = level;
         other_held = less_btn;
      end else begin
         less_btn = level;
         other_held = more_btn;
      end
      if (level) begin
         jog_active = 1'b1;
         axis_step = own;
      end else if (other_held) begin
         axis_step = -own;
      end else begin
         jog_active = 1'b0;
         axis_step = '0;
      end
   endfunction

   // A stop button edge: press steers against the value, release restores a lone direction.
   function automatic void press_stop(logic level);
      logic signed [15:0] size;
      size = $signed({1'b0, jog_step_size});
      stop_btn = level;
      if (level) begin
         if (axis_val > 0) axis_step = -size;
         else if (axis_val < 0) axis_step = size;
      end else begin
         if (less_btn && !more_btn) axis_step = -size;
         else if (!less_btn && more_btn) axis_step = size;
      end
   endfunction

   // Watch all three channels on the rising edge.
   always @(posedge clock) begin : watch
      axis_report_type got;
      axis_report_type want;
      if (reset) begin
         damp_q16      = jrc_pkg::DAMP_RESET;
         jog_step_size = jrc_pkg::STEP_RESET;
         upper_lim     = jrc_pkg::UPPER_RESET;
         lower_lim     = jrc_pkg::LOWER_RESET;
         lin_decay     = jrc_pkg::LINEAR_RESET;
         mul_decay     = jrc_pkg::MULTIPLY_RESET;
         axis_val      = '0;
         axis_step     = '0;
         more_btn      = 1'b0;
         less_btn      = 1'b0;
         stop_btn      = 1'b0;
         jog_active    = 1'b0;
         axis_reports_q.delete();
         fails         = 0;
         compared      = 0;
      end else begin
         // Compare a response beat with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.axis   = rsp_tdata[15:0];
            got.active = rsp_tdata[16];
            if (axis_reports_q.size() == 0) begin
               fails++;
               $display("%0t: response beat with nothing outstanding, %s %0d/%0b",
                        $time, "expected none, actual", got.axis, got.active);
            end else begin
               want = axis_reports_q.pop_front();
               compared++;
               if (got.axis !== want.axis) begin
                  fails++;
                  $display("%0t: axis_value mismatch, expected %0d, actual %0d",
                           $time, want.axis, got.axis);
               end
               if (got.active !== want.active) begin
                  fails++;
                  $display("%0t: is_active mismatch, expected %0b, actual %0b",
                           $time, want.active, got.active);
               end
            end
         end

         // Register writes; unknown indexes are ignored.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               jrc_pkg::REG_DAMP:     damp_q16 = csr_data;
               jrc_pkg::REG_STEP:     jog_step_size = csr_data[14:0];
               jrc_pkg::REG_UPPER:    upper_lim = csr_data;
               jrc_pkg::REG_LOWER:    lower_lim = csr_data;
               jrc_pkg::REG_LINEAR:   lin_decay = csr_data[0];
               jrc_pkg::REG_MULTIPLY: mul_decay = csr_data[0];
               default: ;
            endcase
         end

         // Every command beat yields exactly one response.
         if (req_tvalid && req_tready) begin
            case (jrc_pkg::jrc_cmd_type'(req_tuser))
               jrc_pkg::CMD_TICK: age_axis();
               jrc_pkg::CMD_LESS: press_direction(req_tdata[0], 1'b0);
               jrc_pkg::CMD_MORE: press_direction(req_tdata[0], 1'b1);
               default:           press_stop(req_tdata[0]);
            endcase
            want.axis   = axis_val;
            want.active = jog_active;
            axis_reports_q.push_back(want);
         end
      end
      fail_count     <= fails;
      compared_count <= compared;
      pending_count  <= axis_reports_q.size();
   end

endmodule

FILE: sim/jog_ramp_controller_with_damping_unit_tb.sv
// Stimulus and verdict for the jog ramp controller with damping.
`timescale 1ns / 1ps

module jog_ramp_controller_with_damping_unit_tb;

   import jrc_pkg::*;

   localparam int BURST_ITEMS = 180;
   localparam int CYCLE_LIMIT = 200000;

   // Indexes beyond the register file, which the block must ignore.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;  // [0] button_level
   logic [1:0]                 req_tuser  = '0;  // [1:0] cmd
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b1;
   logic [23:0]                rsp_tdata;        // [15:0] axis_value, [16] is_active
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data   = '0;

   int fail_count;
   int pending_count;
   int compared_count;

   int   cycle_count = 0;
   int   cmds_sent   = 0;
   int   reg_writes  = 0;
   int   settings    = 0;
   logic idle_req    = 1'b1;
   logic stall_rsp   = 1'b1;
   int   rsp_hold    = 0;
   logic rsp_taken   = 1'b0;
   logic rsp_seen    = 1'b0;

   jog_ramp_controller_with_damping_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   jrc_axis_checker u_axis_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .compared_count (compared_count)
   );

   // Free-running clock, 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("jog_ramp_controller_with_damping_unit verification failed");
         $finish;
      end
   end

   // Response side: after each beat taken, hold ready low for a random number of
   // cycles in which a beat is on offer.
   always @(posedge clock) begin
      rsp_taken <= rsp_tvalid && rsp_tready;
      rsp_seen  <= rsp_tvalid;
   end

   always @(negedge clock) begin
      if (rsp_taken) rsp_hold = stall_rsp ? $urandom_range(0, 4) : 0;
      else if (rsp_hold > 0 && rsp_seen) rsp_hold = rsp_hold - 1;
      rsp_tready <= (rsp_hold == 0);
   end

   // Offer one command beat, after a random gap if idle_req, and wait until taken.
   task automatic send_cmd(jrc_cmd_type cmd, logic level);
      int gap;
      gap = idle_req ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      cmds_sent++;
   endtask

   // Stop sending and wait until every response has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write beat.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] word);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   // Write the whole register set; unused bits of the mode flags get noise.
   task automatic load_settings(logic [15:0] damp, logic [15:0] step_word,
                                logic [15:0] upper, logic [15:0] lower,
                                logic lin, logic mul);
      logic [14:0] noise_a;
      logic [14:0] noise_b;
      noise_a = 15'($urandom);
      noise_b = 15'($urandom);
      write_reg(REG_DAMP, damp);
      write_reg(REG_STEP, step_word);
      write_reg(REG_UPPER, upper);
      write_reg(REG_LOWER, lower);
      write_reg(REG_LINEAR, {noise_a, lin});
      write_reg(REG_MULTIPLY, {noise_b, mul});
      settings++;
   endtask

   task automatic random_settings(logic ordered);
      logic [15:0] damp;
      logic [15:0] step_word;
      logic [15:0] upper;
      logic [15:0] lower;
      damp = 16'($urandom);
      step_word = 16'($urandom);
      if ($urandom_range(0, 3) != 0) step_word = 16'($urandom_range(0, 1500));
      if (ordered) begin
         upper = 16'($urandom_range(0, 32767));
         lower = 16'(-$urandom_range(0, 32768));
      end else begin
         upper = 16'($urandom);
         lower = 16'($urandom);
      end
      load_settings(damp, step_word, upper, lower,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // A well-formed jog: press, ramp, maybe stop, maybe counter-press, release, coast.
   task automatic jog_gesture();
      jrc_cmd_type dir;
      jrc_cmd_type other;
      dir   = $urandom_range(0, 1) ? CMD_MORE : CMD_LESS;
      other = (dir == CMD_MORE) ? CMD_LESS : CMD_MORE;
      send_cmd(dir, 1'b1);
      repeat ($urandom_range(1, 12)) send_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) begin
         send_cmd(CMD_STOP, 1'b1);
         repeat ($urandom_range(0, 4)) send_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
         send_cmd(CMD_STOP, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
         send_cmd(other, 1'b1);
         repeat ($urandom_range(0, 4)) send_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
         send_cmd(other, 1'b0);
      end
      send_cmd(dir, 1'b0);
      repeat ($urandom_range(0, 10)) send_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
   endtask

   // Random traffic under the current settings, then wait for it to settle.
   task automatic run_phase(logic idle, logic stall);
      int target;
      idle_req  = idle;
      stall_rsp = stall;
      target    = cmds_sent + BURST_ITEMS;
      while (cmds_sent < target) begin
         if ($urandom_range(0, 3) != 0) jog_gesture();
         else send_cmd(jrc_cmd_type'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)));
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stop on a zero value, release with nothing held, both directions
      // held, hand-over from one direction to the other, stop press and release.
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_STOP, 1'b1);
      send_cmd(CMD_STOP, 1'b0);
      send_cmd(CMD_MORE, 1'b1);
      repeat (3) send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_LESS, 1'b1);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_MORE, 1'b0);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_STOP, 1'b1);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_STOP, 1'b0);
      send_cmd(CMD_LESS, 1'b0);
      send_cmd(CMD_TICK, 1'b1);

      // A held press keeps the step it latched, even after a new step size.
      send_cmd(CMD_MORE, 1'b1);
      drain();
      write_reg(REG_STEP, 16'd2000);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_MORE, 1'b0);
      send_cmd(CMD_TICK, 1'b0);
      drain();
      write_reg(REG_STEP, {1'b0, STEP_RESET});

      // Register defaults.
      run_phase(1'b1, 1'b1);

      // Linear decay, plus writes to indexes outside the register file.
      load_settings(DAMP_RESET, 16'd700, UPPER_RESET, LOWER_RESET, 1'b1, 1'b0);
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0000);
      run_phase(1'b1, 1'b0);

      // Zero damping, largest step, widest bounds; multiply overrides linear.
      load_settings(16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 1'b1);
      run_phase(1'b0, 1'b1);

      // Full damping and inverted bounds; the top step bit is dropped.
      load_settings(16'hFFFF, 16'hFFFF, -16'sd100, 16'sd100, 1'b0, 1'b1);
      run_phase(1'b1, 1'b1);

      // No decay at all, back to back on both sides.
      load_settings(16'd1000, 16'd3000, 16'sd12000, -16'sd9000, 1'b0, 1'b0);
      run_phase(1'b0, 1'b0);

      // Linear mode with a zero step.
      load_settings(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
      run_phase(1'b1, 1'b1);

      // Random settings.
      random_settings(1'b1);
      run_phase(1'b1, 1'b1);
      random_settings(1'b0);
      run_phase(1'b1, 1'b0);
      random_settings(1'b1);
      run_phase(1'b0, 1'b1);
      random_settings(1'b0);
      run_phase(1'b1, 1'b1);

      $display("Run drove %0d commands and %0d register writes across %0d register settings,",
               cmds_sent, reg_writes, settings + 1);
      $display("with %0d responses compared against the predicted axis value and active flag.",
               compared_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("jog_ramp_controller_with_damping_unit verification clean");
      end else begin
         $display("jog_ramp_controller_with_damping_unit verification failed");
      end
      $finish;
   end

endmodule
